// ===== hw/rtl/mcd_pkg.sv =====
// shared types, constants and sine table for the multitone downconverter
package mcd_pkg;

  localparam int MAX_TONES       = 16;
  localparam int DECIM           = 16;
  localparam int WINDOW          = 17;
  localparam int SIN_TABLE_DEPTH = 1024;
  localparam int NUM_STAGES      = 4;
  localparam int NUM_CHANS       = 2 * MAX_TONES;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 40;
  localparam int FILT_W   = 56;
  localparam int TONE_W   = 4;
  localparam int CHAN_W   = $clog2(NUM_CHANS);
  localparam int STAGE_W  = $clog2(NUM_STAGES);
  localparam int IDX_W    = $clog2(SIN_TABLE_DEPTH);
  localparam int DECIM_W  = $clog2(DECIM + 1);
  localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_DEPTH  = NUM_CHANS * NUM_STAGES;
  localparam int SUM_AW     = $clog2(SUM_DEPTH);
  localparam int HIST_DEPTH = SUM_DEPTH * WINDOW;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CLR_W      = $clog2(HIST_DEPTH + 1);
  localparam int QUARTER    = SIN_TABLE_DEPTH / 4;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TONES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_STEP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_PERIOD = 8'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_MIX_DONE,
    ST_FILT_RD,
    ST_FILT_WR,
    ST_EMIT
  } state_t;

  typedef logic [QUARTER*COEF_W-1:0] qtr_rom_t;

  // quarter-wave folded q30 taylor series, rounded to q1.15
  function automatic logic signed [COEF_W-1:0] sine_q15(logic [31:0] phase);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    quad = phase[31:30];
    r = {34'd0, phase[29:0]};
    if (quad[0]) r = (64'd1 << 30) - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (n % 2 == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    q = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (q > 64'sd32767) q = 64'sd32767;
    if (quad[1]) q = -q;
    return COEF_W'(q);
  endfunction

  // first quadrant of the sine table; the rest follows by symmetry
  function automatic qtr_rom_t build_qtr_rom();
    qtr_rom_t    rom;
    logic [31:0] p;
    rom = '0;
    for (int i = 0; i < QUARTER; i++) begin
      p = 32'((64'(i) << 32) / SIN_TABLE_DEPTH);
      rom[i*COEF_W +: COEF_W] = sine_q15(p);
    end
    return rom;
  endfunction

  localparam qtr_rom_t QTR_ROM = build_qtr_rom();
  // value at a quarter turn, reached when folding hits the quadrant edge
  localparam logic signed [COEF_W-1:0] SIN_PEAK = sine_q15(32'h40000000);

endpackage

// ===== hw/rtl/mcd_ram.sv =====
// generic single-write ram with registered read
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/multitone_iq_cic_downconverter_core.sv =====
// top level: multitone quadrature mixer with four-stage moving-sum decimator
// After reset the block clears its filter history with in_ready low;
// configuration writes are taken meanwhile. For each sample one
// shared 16x16 multiplier forms the 32 I/Q products one per cycle, then the last
// product is accumulated from its register. Every DECIM-th sample adds a filter update
// that reads and then writes each channel and stage, since the history and running-sum
// rams have a registered read, followed by one output transfer per active tone (at least
// one, at most MAX_TONES), each taken when out_ready is high.
module multitone_iq_cic_downconverter_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mcd_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mcd_pkg::SAMPLE_W-1:0]   mic_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mcd_pkg::TONE_W-1:0]            tone_index,
  output logic signed [mcd_pkg::FILT_W-1:0]     in_phase,
  output logic signed [mcd_pkg::FILT_W-1:0]     quadrature,
  output logic                                  last_tone
);
  import mcd_pkg::*;

  state_t state, state_next;

  logic [4:0]  active_tones;
  logic [31:0] base_phase_step;
  logic [31:0] tone_spacing_step;
  logic [15:0] phase_period;

  logic [15:0]         phase_counter;
  logic [DECIM_W-1:0]  decim_counter;
  logic [PTR_W-1:0]    history_pointer;
  logic [31:0]         tone_phase [MAX_TONES];
  logic [ACC_W-1:0]    decim_accum [NUM_CHANS];
  logic [FILT_W-1:0]   res_i [MAX_TONES];
  logic [FILT_W-1:0]   res_q [MAX_TONES];

  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;
  logic [31:0]                step;
  logic [CHAN_W-1:0]          ch;
  logic signed [PROD_W-1:0]   prod;
  logic [CHAN_W-1:0]          prod_ch;
  logic                       prod_vld;
  logic [CHAN_W+STAGE_W-1:0]  cs;
  logic [FILT_W-1:0]          v;
  logic [CLR_W-1:0]           clr;
  logic [TONE_W-1:0]          emit_k;
  logic [TONE_W-1:0]          n_last;

  logic [TONE_W-1:0]          mix_k;
  logic [IDX_W-1:0]           sin_idx;
  logic [IDX_W-1:0]           cos_idx;
  logic [IDX_W-1:0]           lut_idx;
  logic [1:0]                 lut_quad;
  logic [IDX_W-2:0]           lut_fold;
  logic signed [COEF_W-1:0]   lut_mag;
  logic signed [COEF_W-1:0]   lut_val;
  logic signed [COEF_W-1:0]   coef;
  logic [16:0]                pc_inc;
  logic [CHAN_W-1:0]          filt_c;
  logic [STAGE_W-1:0]         filt_s;
  logic [FILT_W-1:0]          vin;

  logic                hist_we;
  logic [HIST_AW-1:0]  hist_addr;
  logic [HIST_AW-1:0]  hist_waddr;
  logic [FILT_W-1:0]   hist_wdata;
  logic [FILT_W-1:0]   hist_rdata;
  logic                sum_we;
  logic [SUM_AW-1:0]   sum_waddr;
  logic [FILT_W-1:0]   sum_wdata;
  logic [FILT_W-1:0]   sum_rdata;

  mcd_ram #(.WIDTH(FILT_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_addr), .rdata(hist_rdata)
  );

  mcd_ram #(.WIDTH(FILT_W), .DEPTH(SUM_DEPTH)) u_sums (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(SUM_AW'(cs)), .rdata(sum_rdata)
  );

  assign mix_k   = ch[CHAN_W-1:1];
  assign sin_idx = tone_phase[mix_k][31 -: IDX_W];
  assign cos_idx = sin_idx + IDX_W'(QUARTER);

  // quarter-wave lookup: mirror odd quadrants, negate the lower half cycle
  assign lut_idx  = ch[0] ? sin_idx : cos_idx;
  assign lut_quad = lut_idx[IDX_W-1 -: 2];
  assign lut_fold = lut_quad[0] ? (IDX_W-1)'(QUARTER) - {1'b0, lut_idx[IDX_W-3:0]}
                                : {1'b0, lut_idx[IDX_W-3:0]};
  assign lut_mag  = lut_fold[IDX_W-2] ? SIN_PEAK
                  : signed'(QTR_ROM[COEF_W*int'(lut_fold[IDX_W-3:0]) +: COEF_W]);
  assign lut_val  = lut_quad[1] ? -lut_mag : lut_mag;
  assign coef     = ch[0] ? -lut_val : lut_val;
  assign pc_inc  = {1'b0, phase_counter} + 17'd1;

  assign filt_c    = cs[CHAN_W+STAGE_W-1:STAGE_W];
  assign filt_s    = cs[STAGE_W-1:0];
  assign hist_addr = HIST_AW'(HIST_AW'(cs) * HIST_AW'(WINDOW) + HIST_AW'(history_pointer));
  assign vin = (filt_s == '0)
             ? {{(FILT_W-ACC_W){decim_accum[filt_c][ACC_W-1]}}, decim_accum[filt_c]} : v;

  assign tone_index = emit_k;
  assign in_phase   = res_i[emit_k];
  assign quadrature = res_q[emit_k];
  assign last_tone  = (emit_k == n_last);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = hist_addr;
    hist_wdata = vin;
    sum_we     = 1'b0;
    sum_waddr  = SUM_AW'(cs);
    sum_wdata  = sum_rdata + vin - hist_rdata;
    unique case (state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = HIST_AW'(clr);
        hist_wdata = '0;
        sum_we     = (clr < CLR_W'(SUM_DEPTH));
        sum_waddr  = SUM_AW'(clr);
        sum_wdata  = '0;
        if (clr == CLR_W'(HIST_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_MIX;
      end
      ST_MIX: begin
        if (ch == CHAN_W'(NUM_CHANS - 1)) state_next = ST_MIX_DONE;
      end
      ST_MIX_DONE: begin
        if (decim_counter == DECIM_W'(DECIM - 1)) state_next = ST_FILT_RD;
        else state_next = ST_IDLE;
      end
      ST_FILT_RD: state_next = ST_FILT_WR;
      ST_FILT_WR: begin
        hist_we = 1'b1;
        sum_we  = 1'b1;
        if (cs == '1) state_next = ST_EMIT;
        else state_next = ST_FILT_RD;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && last_tone) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_tones      <= 5'd16;
      base_phase_step   <= 32'd1565873476;
      tone_spacing_step <= 32'd31317470;
      phase_period      <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_TONES: active_tones      <= cfg_data[4:0];
        REG_BASE_STEP:    base_phase_step   <= cfg_data;
        REG_SPACING_STEP: tone_spacing_step <= cfg_data;
        REG_PHASE_PERIOD: phase_period      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_counter   <= '0;
      decim_counter   <= '0;
      history_pointer <= '0;
      clr             <= '0;
      ch              <= '0;
      cs              <= '0;
      emit_k          <= '0;
      prod_vld        <= 1'b0;
      for (int i = 0; i < MAX_TONES; i++) tone_phase[i] <= '0;
      for (int i = 0; i < NUM_CHANS; i++) decim_accum[i] <= '0;
    end else begin
      prod_vld <= 1'b0;
      // product of the previous cycle lands in its channel accumulator
      if (prod_vld) begin
        decim_accum[prod_ch] <= decim_accum[prod_ch]
                              + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
      unique case (state)
        ST_CLEAR: clr <= clr + CLR_W'(1);
        ST_IDLE: begin
          if (in_valid) begin
            sample  <= mic_sample;
            step    <= base_phase_step;
            ch      <= '0;
            restart <= (pc_inc >= {1'b0, phase_period});
            phase_counter <= (pc_inc >= {1'b0, phase_period}) ? '0 : pc_inc[15:0];
          end
          emit_k <= '0;
          if (active_tones == 5'd0) n_last <= '0;
          else if (active_tones > 5'(MAX_TONES)) n_last <= TONE_W'(MAX_TONES - 1);
          else n_last <= TONE_W'(active_tones - 5'd1);
        end
        ST_MIX: begin
          prod     <= PROD_W'(sample * coef);
          prod_ch  <= ch;
          prod_vld <= 1'b1;
          ch       <= ch + CHAN_W'(1);
          // oscillator advances after its quadrature product
          if (ch[0]) begin
            tone_phase[mix_k] <= restart ? '0 : tone_phase[mix_k] + step;
            step <= step + tone_spacing_step;
          end
        end
        ST_MIX_DONE: begin
          cs <= '0;
          if (decim_counter == DECIM_W'(DECIM - 1)) decim_counter <= '0;
          else decim_counter <= decim_counter + DECIM_W'(1);
        end
        ST_FILT_RD: ;
        ST_FILT_WR: begin
          v  <= sum_rdata;
          cs <= cs + (CHAN_W+STAGE_W)'(1);
          if (filt_s == '0) decim_accum[filt_c] <= '0;
          if (filt_s == STAGE_W'(NUM_STAGES - 1)) begin
            if (filt_c[0]) res_q[filt_c[CHAN_W-1:1]] <= sum_rdata;
            else res_i[filt_c[CHAN_W-1:1]] <= sum_rdata;
          end
          if (cs == '1) begin
            if (history_pointer == PTR_W'(WINDOW - 1)) history_pointer <= '0;
            else history_pointer <= history_pointer + PTR_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_ready && !last_tone) emit_k <= emit_k + TONE_W'(1);
        end
        default: ;
      endcase
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while results pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second sample taken mid work");

  a_tone_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_tone) |=>
      (out_valid && tone_index == $past(tone_index) + 4'd1))
    else $error("tone pairs out of order");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_tone) |=> in_ready)
    else $error("block not idle after last pair");

  a_decim_range: assert property (@(posedge clk) disable iff (rst)
    decim_counter < DECIM_W'(DECIM)) else $error("decimation count out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the multitone quadrature down-converter
`timescale 1ns / 100ps

module tb_top;
  import mcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [TONE_W-1:0]        tone;
    logic signed [FILT_W-1:0] i_val;
    logic signed [FILT_W-1:0] q_val;
    logic                     last;
  } iq_pair_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] mic_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [TONE_W-1:0]          tone_index;
  logic signed [FILT_W-1:0]   in_phase;
  logic signed [FILT_W-1:0]   quadrature;
  logic                       last_tone;

  multitone_iq_cic_downconverter_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mixer / filter predictor state
  logic signed [COEF_W-1:0] sin_lut [SIN_TABLE_DEPTH];
  logic signed [COEF_W-1:0] cos_lut [SIN_TABLE_DEPTH];
  logic [4:0]               tones_reg;
  logic [31:0]              base_reg;
  logic [31:0]              spacing_reg;
  logic [15:0]              period_reg;
  logic [15:0]              period_cnt;
  int                       decim_cnt;
  logic [31:0]              osc_phase [MAX_TONES];
  logic signed [63:0]       chan_acc [NUM_CHANS];
  logic [FILT_W-1:0]        window_hist [NUM_CHANS][NUM_STAGES][WINDOW];
  int                       hist_ptr;

  iq_pair_t                   pending_pairs[$];
  logic signed [SAMPLE_W-1:0] sample_queue[$];
  int                         fail_count = 0;

  // sender / receiver controls
  bit tx_pause = 1'b0;
  bit tx_idle_en = 1'b1;
  bit rx_stall_en = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  function automatic logic signed [COEF_W-1:0] q15_sine(logic [31:0] ph);
    logic [63:0]        r, x, xsq, t;
    logic signed [63:0] acc, scaled;
    r = {34'd0, ph[29:0]};
    if (ph[30]) r = (64'd1 << 30) - r;
    x = (r * 64'd1686629713) >> 30;
    xsq = (x * x + (64'd1 << 29)) >> 30;
    t = x;
    acc = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      t = ((t * xsq) >> 30) / 64'((2 * n) * (2 * n + 1));
      acc = (n % 2) ? acc - $signed(t) : acc + $signed(t);
    end
    if (acc < 0) acc = 0;
    scaled = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (scaled > 32767) scaled = 32767;
    if (ph[31]) scaled = -scaled;
    return scaled[COEF_W-1:0];
  endfunction

  task automatic mix_sample(logic signed [SAMPLE_W-1:0] smp);
    logic [IDX_W-1:0]  lut_idx;
    logic [FILT_W-1:0] v, s_sum;
    logic [FILT_W-1:0] outs [NUM_CHANS];
    int                n_out;
    iq_pair_t          pr;
    for (int k = 0; k < MAX_TONES; k++) begin
      lut_idx = osc_phase[k][31:32-IDX_W];
      chan_acc[2*k]   += 64'(smp) * 64'(cos_lut[lut_idx]);
      chan_acc[2*k+1] -= 64'(smp) * 64'(sin_lut[lut_idx]);
    end
    period_cnt++;
    if (period_cnt >= period_reg) begin
      period_cnt = 0;
      foreach (osc_phase[k]) osc_phase[k] = '0;
    end else begin
      foreach (osc_phase[k]) osc_phase[k] += base_reg + 32'(k) * spacing_reg;
    end
    decim_cnt++;
    if (decim_cnt < DECIM) return;
    decim_cnt = 0;
    for (int c = 0; c < NUM_CHANS; c++) begin
      v = chan_acc[c][FILT_W-1:0];
      chan_acc[c] = 0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        s_sum = '0;
        for (int w = 0; w < WINDOW; w++) s_sum += window_hist[c][s][w];
        window_hist[c][s][hist_ptr] = v;
        v = s_sum;
      end
      outs[c] = v;
    end
    hist_ptr = (hist_ptr + 1 >= WINDOW) ? 0 : hist_ptr + 1;
    n_out = (tones_reg == 0) ? 1 : (tones_reg > MAX_TONES) ? MAX_TONES : tones_reg;
    for (int k = 0; k < n_out; k++) begin
      pr.tone  = TONE_W'(k);
      pr.i_val = outs[2*k];
      pr.q_val = outs[2*k+1];
      pr.last  = (k == n_out - 1);
      pending_pairs.push_back(pr);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ACTIVE_TONES: tones_reg = val[4:0];
      REG_BASE_STEP:    base_reg = val;
      REG_SPACING_STEP: spacing_reg = val;
      REG_PHASE_PERIOD: period_reg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || pending_pairs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // sender: bursts with random gaps
  bit in_took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) mix_sample(mic_sample);
  end

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = tx_idle_en ? $urandom_range(0, 30) : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!rst && !tx_pause && sample_queue.size() != 0) begin
        in_valid <= 1'b1;
        mic_sample <= sample_queue.pop_front();
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: periodic stall pattern plus one long hold-off
  int rx_cyc = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = 3000;
      out_ready <= 1'b0;
    end else if (rx_stall_en) begin
      out_ready <= ((rx_cyc % 11) >= 3) && ($urandom_range(0, 4) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    iq_pair_t exp_pr;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected transfer: tone_index %0d", tone_index);
        fail_count++;
      end else begin
        exp_pr = pending_pairs.pop_front();
        if (tone_index !== exp_pr.tone) begin
          $error("tone_index: expected %0d, got %0d", exp_pr.tone, tone_index);
          fail_count++;
        end
        if (in_phase !== exp_pr.i_val) begin
          $error("in_phase: expected %0d, got %0d", exp_pr.i_val, in_phase);
          fail_count++;
        end
        if (quadrature !== exp_pr.q_val) begin
          $error("quadrature: expected %0d, got %0d", exp_pr.q_val, quadrature);
          fail_count++;
        end
        if (last_tone !== exp_pr.last) begin
          $error("last_tone: expected %0d, got %0d", exp_pr.last, last_tone);
          fail_count++;
        end
      end
    end
  end

  // register settings per phase: tones, base, spacing, period
  logic [CFG_W-1:0] phase_cfg [8][4] = '{
    '{32'd1,  32'd0,          32'd0,          32'd1},
    '{32'd0,  32'hffffffff,   32'hffffffff,   32'd0},
    '{32'd31, 32'd1565873476, 32'd31317470,   32'd65535},
    '{32'd16, 32'h40000000,   32'h01000000,   32'd5},
    '{32'd7,  32'hdeadbeef,   32'h12345678,   32'd37},
    '{32'hffffffe5, 32'h7fffffff, 32'h80000001, 32'hffff0010},
    '{32'd16, 32'd1565873476, 32'd31317470,   32'd512},
    '{32'd3,  32'h00400000,   32'hffc00000,   32'd200}
  };

  initial begin
    logic signed [SAMPLE_W-1:0] directed [20] = '{
      16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, 16'shaaaa,
      16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh00ff, 16'shff00,
      16'sh0f0f, 16'shf0f0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh4000
    };
    for (int i = 0; i < SIN_TABLE_DEPTH; i++) begin
      sin_lut[i] = q15_sine(32'((64'(i) << 32) / SIN_TABLE_DEPTH));
      cos_lut[i] = q15_sine(32'((64'(i) << 32) / SIN_TABLE_DEPTH) + 32'h40000000);
    end
    tones_reg = 5'd16;
    base_reg = 32'd1565873476;
    spacing_reg = 32'd31317470;
    period_reg = 16'd512;
    period_cnt = '0;
    decim_cnt = 0;
    hist_ptr = 0;
    foreach (osc_phase[k]) osc_phase[k] = '0;
    foreach (chan_acc[c]) chan_acc[c] = 0;
    foreach (window_hist[c, s, w]) window_hist[c][s][w] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) sample_queue.push_back(directed[i]);
    repeat (12) sample_queue.push_back(rand_sample());
    drain();
    write_reg(REG_UNMAPPED, 32'h00000001);

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_ACTIVE_TONES, phase_cfg[p][0]);
      write_reg(REG_BASE_STEP, phase_cfg[p][1]);
      write_reg(REG_SPACING_STEP, phase_cfg[p][2]);
      write_reg(REG_PHASE_PERIOD, phase_cfg[p][3]);
      tx_idle_en = (p % 3 != 1);
      rx_stall_en = (p % 4 != 2);
      if (p == 3) long_hold_req = 1'b1;
      repeat ($urandom_range(44, 56)) sample_queue.push_back(rand_sample());
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mcd_pkg.sv
hw/rtl/mcd_ram.sv
hw/rtl/multitone_iq_cic_downconverter_core.sv
tb/sv/tb_top.sv
